// ----- rtl/lph_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 16;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_PROBE,
    S_DONE
  } state_e;

  // write controls toward the slot store
  typedef struct packed {
    logic key_we;
    logic valid_we;
    logic valid_wd;
  } wr_ctrl_t;

endpackage

// ----- rtl/lph_home.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_home
// Home slot unit: key modulo the table size, a mask when the size is a power
// of two, else a reciprocal multiplication and a back multiplication.
// ----------------------------------------------------------------------------
module lph_home #(
  parameter int unsigned TableSize = lph_pkg::TABLE_SIZE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [lph_pkg::KEY_W-1:0]         key_i,
  output logic                              done_o,
  output logic [$clog2(TableSize)-1:0]      home_o
);
  import lph_pkg::*;

  localparam int unsigned AW = $clog2(TableSize);

  if ((TableSize & (TableSize - 1)) == 0) begin : g_mask
    logic          done_q;
    logic [AW-1:0] home_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        home_q <= key_i[AW-1:0];
      end
    end

    assign done_o = done_q;
    assign home_o = home_q;
  end else begin : g_recip
    // quotient is exact for every key of KEY_W bits
    localparam int unsigned     SH      = KEY_W + AW;
    localparam longint unsigned RECIP   =
      ((64'd1 << SH) + 64'(TableSize) - 64'd1) / 64'(TableSize);
    localparam logic [KEY_W:0]   RECIP_K = (KEY_W+1)'(RECIP);
    localparam logic [KEY_W-1:0] SIZE_K  = KEY_W'(TableSize);

    logic             st1_q;
    logic             st2_q;
    logic             done_q;
    logic [KEY_W-1:0] key_q;
    logic [KEY_W-1:0] quo_q;
    logic [AW-1:0]    home_q;
    logic [2*KEY_W:0] prod;
    logic [KEY_W-1:0] quo;
    logic [KEY_W-1:0] rem;

    assign prod = (2*KEY_W+1)'(key_q) * (2*KEY_W+1)'(RECIP_K);
    assign quo  = KEY_W'(prod >> SH);
    assign rem  = key_q - KEY_W'(quo_q * SIZE_K);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st1_q  <= 1'b0;
        st2_q  <= 1'b0;
        done_q <= 1'b0;
      end else begin
        st1_q  <= start_i;
        st2_q  <= st1_q;
        done_q <= st2_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= key_i;
      end
      if (st1_q) begin
        quo_q <= quo;
      end
      if (st2_q) begin
        home_q <= rem[AW-1:0];
      end
    end

    assign done_o = done_q;
    assign home_o = home_q;
  end

endmodule

// ----- rtl/lph_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_store
// Slot store: key memory and valid memory, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module lph_store #(
  parameter int unsigned TableSize = lph_pkg::TABLE_SIZE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(TableSize)-1:0] rd_addr_i,
  input  lph_pkg::wr_ctrl_t            wr_i,
  input  logic [$clog2(TableSize)-1:0] wr_addr_i,
  input  logic [lph_pkg::KEY_W-1:0]    wr_key_i,
  output logic [lph_pkg::KEY_W-1:0]    rd_key_o,
  output logic                         rd_valid_o
);
  import lph_pkg::*;

  logic [KEY_W-1:0] key_mem   [TableSize];
  logic             valid_mem [TableSize];
  logic [KEY_W-1:0] rd_key_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (rd_en_i) begin
      rd_key_q <= key_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.valid_we) begin
      valid_mem[wr_addr_i] <= wr_i.valid_wd;
    end
    if (rd_en_i) begin
      rd_valid_q <= valid_mem[rd_addr_i];
    end
  end

  assign rd_key_o   = rd_key_q;
  assign rd_valid_o = rd_valid_q;

endmodule

// ----- rtl/linear_probe_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing hash table with linear probing; insert, lookup and remove.
// ----------------------------------------------------------------------------
// After reset the block sweeps the valid memory and takes no transaction
// meanwhile. Each operation then runs one at a time: it is taken, its home
// slot is formed (by a mask when TableSize is a power of two, by reciprocal
// multiplication otherwise), one memory read is made per probed slot (1 to
// TableSize), and the result register is loaded once it is free. An undefined
// op code skips the home slot and the probe. The probe loop over the single
// memory read port sets the worst case. A result waits in its output
// register while the next operation is taken.
module linear_probe_hash_table #(
  parameter int unsigned TableSize = lph_pkg::TABLE_SIZE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lph_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // key[30:0]
  input  logic [lph_pkg::OP_W-1:0]         s_axis_tuser,  // op[1:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lph_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // slot[3:0], live_count[8:4]
  output logic [lph_pkg::STATUS_W-1:0]     m_axis_tuser   // status[1:0]
);
  import lph_pkg::*;

  localparam int unsigned AW = $clog2(TableSize);
  localparam int unsigned CW = $clog2(TableSize + 1);

  state_e           state_q, state_d;
  op_e              op_q;
  logic [KEY_W-1:0] key_q;
  logic [AW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    n_q, n_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [CW-1:0]    count_q, count_d;
  status_e          res_status_q, res_status_d;
  logic [AW-1:0]    res_slot_q, res_slot_d;

  logic             m_valid_q;
  status_e          m_status_q;
  logic [SLOT_W-1:0]  m_slot_q;
  logic [COUNT_W-1:0] m_count_q;

  logic             in_accept;
  logic             out_load;
  logic             home_done;
  logic [AW-1:0]    home;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  wr_ctrl_t         wr;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] rd_key;
  logic             rd_valid;
  logic             last_probe;
  logic [AW-1:0]    pos_nx;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  lph_home #(
    .TableSize(TableSize)
  ) u_home (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_accept),
    .key_i  (s_axis_tdata[KEY_W-1:0]),
    .done_o (home_done),
    .home_o (home)
  );

  lph_store #(
    .TableSize(TableSize)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .wr_key_i  (key_q),
    .rd_key_o  (rd_key),
    .rd_valid_o(rd_valid)
  );

  assign last_probe = (n_q == AW'(TableSize - 1));
  assign pos_nx     = (pos_q == AW'(TableSize - 1)) ? '0 : pos_q + AW'(1);
  assign wr_addr    = (state_q == S_CLEAR) ? clr_q : pos_q;

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    n_d          = n_q;
    clr_d        = clr_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    rd_en        = 1'b0;
    rd_addr      = pos_nx;
    wr           = '0;
    out_load     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        wr.valid_we = 1'b1;
        wr.valid_wd = 1'b0;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(TableSize - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          res_status_d = STATUS_MISS;
          res_slot_d   = '0;
          if (s_axis_tuser == OP_INSERT || s_axis_tuser == OP_LOOKUP ||
              s_axis_tuser == OP_REMOVE) begin
            state_d = S_HOME;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_HOME: begin
        if (home_done) begin
          rd_en   = 1'b1;
          rd_addr = home;
          pos_d   = home;
          n_d     = '0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        state_d = S_DONE;
        unique case (op_q)
          OP_INSERT: begin
            if (!rd_valid) begin
              wr.key_we    = 1'b1;
              wr.valid_we  = 1'b1;
              wr.valid_wd  = 1'b1;
              count_d      = count_q + CW'(1);
              res_status_d = STATUS_OK;
              res_slot_d   = pos_q;
            end else if (last_probe) begin
              res_status_d = STATUS_FULL;
            end else begin
              state_d = S_PROBE;
            end
          end
          OP_LOOKUP, OP_REMOVE: begin
            if (!rd_valid) begin
              res_status_d = STATUS_MISS;
            end else if (rd_key == key_q) begin
              res_status_d = STATUS_OK;
              res_slot_d   = pos_q;
              if (op_q == OP_REMOVE) begin
                wr.valid_we = 1'b1;
                wr.valid_wd = 1'b0;
                if (count_q != '0) begin
                  count_d = count_q - CW'(1);
                end
              end
            end else if (last_probe) begin
              res_status_d = STATUS_MISS;
            end else begin
              state_d = S_PROBE;
            end
          end
          default: begin
            res_status_d = STATUS_MISS;
          end
        endcase
        if (state_d == S_PROBE) begin
          rd_en = 1'b1;
          pos_d = pos_nx;
          n_d   = n_q + AW'(1);
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= op_e'(s_axis_tuser);
      key_q <= s_axis_tdata[KEY_W-1:0];
    end
    pos_q        <= pos_d;
    n_q          <= n_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    if (out_load) begin
      m_status_q <= res_status_q;
      m_slot_q   <= SLOT_W'(res_slot_q);
      m_count_q  <= COUNT_W'(count_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{(M_TDATA_W - SLOT_W - COUNT_W){1'b0}}, m_count_q, m_slot_q};

endmodule
